### hw/rtl/adss_pkg.sv
// Shared constants, result codes and controller/datapath interface types for the
// advertisement slot select and rotate block. No dependencies.
package adss_pkg;

	// Number of slots in the table, from 1 to 64.
	localparam int SLOT_COUNT = 8;
	// Bits of a slot index inside the block.
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	localparam int ADDR_W = 48;
	localparam int CNT_W = 8;
	localparam int OUT_IDX_W = 6;

	// Stored address word: address type above the 48 address bits.
	localparam int ENTRY_W = ADDR_W + 1;

	localparam logic [CNT_W-1:0] RESET_MAX_ADVERTS = 8'd3;
	localparam logic [CNT_W-1:0] SENDS_MAX = 8'hFF;
	// A random address is stored with its two top bits set.
	localparam logic [1:0] RANDOM_TOP_BITS = 2'b11;

	// Operation codes carried in the input tuser.
	localparam logic OP_PLACE = 1'b0;
	localparam logic OP_TRANSMIT = 1'b1;

	// Pick reason codes.
	localparam logic [1:0] REASON_MATCH = 2'd0;
	localparam logic [1:0] REASON_IDLE = 2'd1;
	localparam logic [1:0] REASON_EVICT = 2'd2;
	localparam logic [1:0] REASON_TRANSMIT = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic commit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_busy;
	} dp_status_t;

endpackage

### hw/rtl/advert_slot_select_and_rotate.sv
// Top level of the advertisement slot select and rotate block.
// Depends on adss_pkg, adss_ctrl and adss_datapath.
//
//  channel  | direction | handshake           | contents
//  s_*      | in        | s_tvalid/s_tready   | address in tdata, op and type in tuser
//  m_*      | out       | m_tvalid/m_tready   | slot index, valid, reason, retired, pending
//  config   | in        | max_adverts_we      | max_adverts, 8 bits, no read-back
//
// An item is accepted, then every slot is scanned through the single registered read
// port of the slot RAMs, the read pipeline is drained and the item is committed. The
// next item is accepted in the cycle after the commit, even while the result still
// waits in the output register; the commit waits only if the previous result has not
// been taken. Reset is asynchronous and clears all slot flags at once, so the block is
// ready in the first cycle after it.
module advert_slot_select_and_rotate import adss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [47:0] s_tdata,   // [47:0] sender_address
	input  logic [1:0] s_tuser,    // [0] op, [1] address_random
	output logic m_tvalid,
	input  logic m_tready,
	output logic [15:0] m_tdata,   // [5:0] slot_index, [6] slot_valid, [8:7] pick_reason,
	                               // [9] slot_retired, [10] pending, [15:11] zero
	input  logic max_adverts_we,
	input  logic [7:0] max_adverts_wdata
);

	dp_cmd_t cmd;
	dp_status_t status;

	adss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	adss_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.in_addr           (s_tdata),
		.in_op             (s_tuser[0]),
		.in_random         (s_tuser[1]),
		.max_adverts_we    (max_adverts_we),
		.max_adverts_wdata (max_adverts_wdata),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tdata           (m_tdata)
	);

endmodule

### hw/rtl/adss_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module adss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/adss_ctrl.sv
// Controller for the slot table: accepts an item, sequences the slot scan and
// the commit. Depends on adss_pkg.
module adss_ctrl import adss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  dp_status_t status,
	output dp_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic [IDX_W-1:0] cnt_q;

	// State and scan counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (s_tvalid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q == IDX_W'(SLOT_COUNT - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (!status.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command decode.
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		cmd.start = s_tready && s_tvalid;
		cmd.rd_en = (state_q == ST_SCAN);
		cmd.rd_idx = cnt_q;
		cmd.commit = (state_q == ST_COMMIT) && !status.out_busy;
	end

endmodule

### hw/rtl/adss_datapath.sv
// Datapath for the slot table: slot storage, scan accumulators, commit and the
// output register. Depends on adss_pkg and adss_ram.
module adss_datapath import adss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  dp_cmd_t cmd,
	output dp_status_t status,
	input  logic [ADDR_W-1:0] in_addr,
	input  logic in_op,
	input  logic in_random,
	input  logic max_adverts_we,
	input  logic [CNT_W-1:0] max_adverts_wdata,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [15:0] m_tdata
);

	// Captured item.
	logic op_q;
	logic rnd_q;
	logic [ADDR_W-1:0] addr_q;

	logic [CNT_W-1:0] max_adverts_q;
	logic [SLOT_COUNT-1:0] written_q;
	logic [SLOT_COUNT-1:0] active_q;
	logic pending_q;

	logic eval_s1;
	logic [IDX_W-1:0] idx_s1;

	// Scan accumulators.
	logic have_match_q;
	logic [IDX_W-1:0] match_q;
	logic have_idle_q;
	logic [IDX_W-1:0] idle_q;
	logic [IDX_W-1:0] most_q;
	logic [CNT_W-1:0] most_cnt_q;
	logic found_q;
	logic [IDX_W-1:0] least_q;
	logic [CNT_W-1:0] least_cnt_q;

	logic m_tvalid_q;
	logic [15:0] m_tdata_q;

	logic [ENTRY_W-1:0] entry_rd;
	logic [CNT_W-1:0] sends_rd;
	logic st_rnd;
	logic [ADDR_W-1:0] st_addr;
	logic [CNT_W-1:0] st_sends;
	logic st_active;

	logic is_place;
	logic [IDX_W-1:0] pick;
	logic [1:0] reason;
	logic [CNT_W-1:0] new_cnt;
	logic retire;
	logic [ADDR_W-1:0] store_addr;
	logic entry_we;
	logic sends_we;
	logic [IDX_W-1:0] sends_waddr;
	logic [CNT_W-1:0] sends_wdata;
	logic [15:0] result;

	adss_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOT_COUNT)) u_entry_ram (
		.clk   (clk),
		.we    (entry_we),
		.waddr (pick),
		.wdata ({rnd_q, store_addr}),
		.re    (cmd.rd_en),
		.raddr (cmd.rd_idx),
		.rdata (entry_rd)
	);

	adss_ram #(.WIDTH(CNT_W), .DEPTH(SLOT_COUNT)) u_sends_ram (
		.clk   (clk),
		.we    (sends_we),
		.waddr (sends_waddr),
		.wdata (sends_wdata),
		.re    (cmd.rd_en),
		.raddr (cmd.rd_idx),
		.rdata (sends_rd)
	);

	// A slot never written reads as public address zero with no sends.
	always_comb begin
		st_rnd = written_q[idx_s1] ? entry_rd[ADDR_W] : 1'b0;
		st_addr = written_q[idx_s1] ? entry_rd[ADDR_W-1:0] : '0;
		st_sends = written_q[idx_s1] ? sends_rd : '0;
		st_active = active_q[idx_s1];
	end

	// Pick, count update and result for the commit cycle.
	always_comb begin
		is_place = (op_q == OP_PLACE);
		if (have_match_q) begin
			pick = match_q;
			reason = REASON_MATCH;
		end else if (have_idle_q) begin
			pick = idle_q;
			reason = REASON_IDLE;
		end else begin
			pick = most_q;
			reason = REASON_EVICT;
		end
		new_cnt = (least_cnt_q == SENDS_MAX) ? SENDS_MAX : least_cnt_q + CNT_W'(1);
		retire = (new_cnt >= max_adverts_q);
		store_addr = rnd_q ? {RANDOM_TOP_BITS, addr_q[ADDR_W-3:0]} : addr_q;
		entry_we = cmd.commit && is_place;
		sends_we = cmd.commit && (is_place || found_q);
		sends_waddr = is_place ? pick : least_q;
		sends_wdata = is_place ? '0 : new_cnt;
		if (is_place) begin
			result = {5'b0, 1'b1, 1'b0, reason, 1'b1, OUT_IDX_W'(pick)};
		end else if (found_q) begin
			result = {5'b0, pending_q, retire, REASON_TRANSMIT, 1'b1, OUT_IDX_W'(least_q)};
		end else begin
			result = {5'b0, 1'b0, 1'b0, REASON_TRANSMIT, 1'b0, OUT_IDX_W'(0)};
		end
	end

	// Captured item, the read pipeline tag and the output data.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q <= in_op;
			rnd_q <= in_random;
			addr_q <= in_addr;
		end
		idx_s1 <= cmd.rd_idx;
		if (cmd.commit) begin
			m_tdata_q <= result;
		end
	end

	// Slot flags, configuration, accumulators and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_adverts_q <= RESET_MAX_ADVERTS;
			written_q <= '0;
			active_q <= '0;
			pending_q <= 1'b0;
			eval_s1 <= 1'b0;
			have_match_q <= 1'b0;
			match_q <= '0;
			have_idle_q <= 1'b0;
			idle_q <= '0;
			most_q <= '0;
			most_cnt_q <= '0;
			found_q <= 1'b0;
			least_q <= '0;
			least_cnt_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (max_adverts_we) begin
				max_adverts_q <= max_adverts_wdata;
			end
			eval_s1 <= cmd.rd_en;
			if (cmd.start) begin
				have_match_q <= 1'b0;
				have_idle_q <= 1'b0;
				most_q <= '0;
				most_cnt_q <= '0;
				found_q <= 1'b0;
			end else if (eval_s1) begin
				if ((st_rnd == rnd_q) && (st_addr == addr_q)) begin
					have_match_q <= 1'b1;
					match_q <= idx_s1;
				end
				if (!st_active) begin
					have_idle_q <= 1'b1;
					idle_q <= idx_s1;
				end
				if (st_sends > most_cnt_q) begin
					most_q <= idx_s1;
					most_cnt_q <= st_sends;
				end
				if (st_active && (!found_q || (st_sends < least_cnt_q))) begin
					found_q <= 1'b1;
					least_q <= idx_s1;
					least_cnt_q <= st_sends;
				end
			end
			if (cmd.commit) begin
				if (is_place) begin
					written_q[pick] <= 1'b1;
					active_q[pick] <= 1'b1;
					pending_q <= 1'b1;
				end else if (found_q) begin
					if (retire) begin
						active_q[least_q] <= 1'b0;
					end
				end else begin
					pending_q <= 1'b0;
				end
			end
			if (cmd.commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign status.out_busy = m_tvalid_q && !m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	// A result is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(m_tvalid_q && !m_tready))
		else $error("result loaded while output still held");

	// A place always leaves the flag raised and its slot active.
	a_place_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && is_place) |=> (pending_q && active_q[$past(pick)]))
		else $error("place did not activate slot or raise pending");

	// A retiring transmit leaves its slot inactive.
	a_retire: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !is_place && found_q && retire) |=> !active_q[$past(least_q)])
		else $error("retired slot still active");

endmodule
